// ===== design/bbc_pkg.sv =====
// shared types, bracket codes and decode helpers for the bracket balance checker
// no dependencies
`default_nettype none

package bbc_pkg;

	// default number of open brackets the stack can hold
	localparam int DEFAULT_STACK_DEPTH = 256;

	// bracket bytes
	localparam logic [7:0] SYM_ROUND_OPEN   = 8'h28;
	localparam logic [7:0] SYM_ROUND_CLOSE  = 8'h29;
	localparam logic [7:0] SYM_SQUARE_OPEN  = 8'h5B;
	localparam logic [7:0] SYM_SQUARE_CLOSE = 8'h5D;
	localparam logic [7:0] SYM_CURLY_OPEN   = 8'h7B;
	localparam logic [7:0] SYM_CURLY_CLOSE  = 8'h7D;

	// bracket kind as held on the stack
	typedef enum logic [1:0] {
		KIND_ROUND  = 2'd0,
		KIND_SQUARE = 2'd1,
		KIND_CURLY  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	// outcome of a string
	typedef enum logic [2:0] {
		R_OK       = 3'd0,
		R_WRONG    = 3'd1,
		R_EMPTY    = 3'd2,
		R_UNCLOSED = 3'd3,
		R_OVERFLOW = 3'd4
	} reason_t;

	// one verdict on its way to the output register
	typedef struct packed {
		logic    valid_res;
		reason_t reason;
	} result_t;

	function automatic logic is_opener(input logic [7:0] sym);
		is_opener = (sym == SYM_ROUND_OPEN) || (sym == SYM_SQUARE_OPEN) ||
			(sym == SYM_CURLY_OPEN);
	endfunction

	function automatic kind_t open_kind(input logic [7:0] sym);
		if (sym == SYM_ROUND_OPEN) begin
			open_kind = KIND_ROUND;
		end else if (sym == SYM_SQUARE_OPEN) begin
			open_kind = KIND_SQUARE;
		end else begin
			open_kind = KIND_CURLY;
		end
	endfunction

	// foreign bytes map to a kind that never sits on the stack
	function automatic kind_t close_kind(input logic [7:0] sym);
		if (sym == SYM_ROUND_CLOSE) begin
			close_kind = KIND_ROUND;
		end else if (sym == SYM_SQUARE_CLOSE) begin
			close_kind = KIND_SQUARE;
		end else if (sym == SYM_CURLY_CLOSE) begin
			close_kind = KIND_CURLY;
		end else begin
			close_kind = KIND_NONE;
		end
	endfunction

endpackage

`default_nettype wire

// ===== design/bbc_if.sv =====
// valid/ready channel interfaces for the bracket balance checker
// no dependencies
`default_nettype none

// one byte of the string per request
interface bbc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       no_symbol;
	logic       is_last;

	modport source (output valid, output symbol, output no_symbol, output is_last,
		input ready);
	modport sink (input valid, input symbol, input no_symbol, input is_last,
		output ready);
endinterface

// one verdict per string
interface bbc_out_if;
	logic       valid;
	logic       ready;
	logic       valid_res;
	logic [2:0] reason;

	modport source (output valid, output valid_res, output reason, input ready);
	modport sink (input valid, input valid_res, input reason, output ready);
endinterface

`default_nettype wire

// ===== design/bbc_stack_mem.sv =====
// bracket stack storage: one write port, one read port with registered read data
// depends on nothing but its parameter
`default_nettype none

module bbc_stack_mem #(
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [1:0]               wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [1:0]               rd_data
);

	logic [1:0] mem [DEPTH];

	// write and registered read; contents are left as they are at reset
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

// ===== design/bbc_out_stage.sv =====
// output register for verdicts, decouples the input side from output stalls
// depends on bbc_pkg and bbc_out_if
`default_nettype none

module bbc_out_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire bbc_pkg::result_t  res,
	output      logic              space,
	bbc_out_if.source              verdict
);
	import bbc_pkg::*;

	logic    valid_q;
	result_t res_q;

	// free when empty or when the held verdict leaves this cycle
	assign space = !valid_q || verdict.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (space && load) begin
			res_q <= res;
		end
	end

	assign verdict.valid     = valid_q;
	assign verdict.valid_res = res_q.valid_res;
	assign verdict.reason    = res_q.reason;

	// a held verdict is flagged valid exactly when its reason is ok
	a_res_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (res_q.valid_res == (res_q.reason == R_OK)))
		else $error("verdict flag disagrees with reason");

	// a stalled verdict stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !verdict.ready) |=> (valid_q && $stable(res_q)))
		else $error("stalled verdict changed");

	// a new verdict is never taken while the register is full and stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !space) |-> 1'b0)
		else $error("verdict dropped on full output register");

endmodule

`default_nettype wire

// ===== design/bracket_balance_checker.sv =====
// bracket balance checker: one byte per cycle while the output register has space; the
// verdict appears in the cycle after the last byte is accepted. this rate is set by the
// single stack memory: the top of the stack lives in a register and the entry below it is
// prefetched from memory every cycle.
// asynchronous reset clears depth, failure state and the output register; stack memory
// is not cleared, there is no clearing pass and requests are taken straight after reset.
// depends on bbc_pkg, bbc_if, bbc_stack_mem, bbc_out_stage
`default_nettype none

module bracket_balance_checker #(
	parameter int STACK_DEPTH = bbc_pkg::DEFAULT_STACK_DEPTH
) (
	input wire logic  clk,
	input wire logic  arst_n,
	bbc_in_if.sink    chars,
	bbc_out_if.source verdict
);
	import bbc_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int DW = $clog2(STACK_DEPTH + 1);

	logic [DW-1:0] depth_q;
	logic          failed_q;
	reason_t       code_q;
	kind_t         top_q;

	logic [DW-1:0] depth_n;
	logic          failed_n;
	reason_t       code_n;
	kind_t         top_n;
	logic [DW-1:0] depth_d;
	logic          failed_d;
	reason_t       code_d;

	logic          fire;
	logic          push;
	logic          load;
	logic          space;
	logic [AW-1:0] rd_addr;
	logic [1:0]    rd_data;
	result_t       res;

	assign chars.ready = space;
	assign fire        = chars.valid && chars.ready;
	assign load        = fire && chars.is_last;

	// push, pop or compare against the top of the stack
	always_comb begin
		depth_n  = depth_q;
		failed_n = failed_q;
		code_n   = code_q;
		top_n    = top_q;
		push     = 1'b0;
		if (fire && !chars.no_symbol && !failed_q) begin
			if (is_opener(chars.symbol)) begin
				if (depth_q == DW'(STACK_DEPTH)) begin
					failed_n = 1'b1;
					code_n   = R_OVERFLOW;
				end else begin
					push    = 1'b1;
					depth_n = depth_q + 1'b1;
					top_n   = open_kind(chars.symbol);
				end
			end else if (depth_q == '0) begin
				failed_n = 1'b1;
				code_n   = R_EMPTY;
			end else if (top_q != close_kind(chars.symbol)) begin
				failed_n = 1'b1;
				code_n   = R_WRONG;
			end else begin
				// the prefetched entry below the top becomes the new top
				depth_n = depth_q - 1'b1;
				top_n   = kind_t'(rd_data);
			end
		end
	end

	// verdict of the string and state for the next one
	always_comb begin
		if (failed_n) begin
			res.reason = code_n;
		end else if (depth_n != '0) begin
			res.reason = R_UNCLOSED;
		end else begin
			res.reason = R_OK;
		end
		res.valid_res = (res.reason == R_OK);
		depth_d  = load ? '0 : depth_n;
		failed_d = load ? 1'b0 : failed_n;
		code_d   = load ? R_OK : code_n;
	end

	// prefetch the entry below the next top; a push never writes that address
	assign rd_addr = (depth_d >= DW'(2)) ? AW'(depth_d - DW'(2)) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q  <= '0;
			failed_q <= 1'b0;
			code_q   <= R_OK;
		end else begin
			depth_q  <= depth_d;
			failed_q <= failed_d;
			code_q   <= code_d;
		end
	end

	always_ff @(posedge clk) begin
		top_q <= top_n;
	end

	bbc_stack_mem #(
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk     (clk),
		.wr_en   (push),
		.wr_addr (depth_q[AW-1:0]),
		.wr_data (2'(top_n)),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	bbc_out_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.res     (res),
		.space   (space),
		.verdict (verdict)
	);

	// depth never passes the stack size
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(STACK_DEPTH))
		else $error("stack depth beyond limit");

	// the last byte of a string leaves a clean state behind
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (depth_q == '0 && !failed_q && code_q == R_OK))
		else $error("state not cleared after last byte");

	// a failure sticks, with its code, until the string ends
	a_fail_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(failed_q && !load) |=> (failed_q && $stable(code_q)))
		else $error("failure lost before end of string");

	// without a request the stack does not move
	a_idle_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(depth_q))
		else $error("stack depth moved without a request");

endmodule

`default_nettype wire
